/* hdl/bhq_pkg.sv */
`timescale 1ns / 1ps

package bhq_pkg;

  // request operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LD,
    ST_DN_CMP,
    ST_PUB
  } bhq_state_t;

  // sift-down decision at one level
  typedef struct packed {
    logic move;   // swap with a child
    logic right;  // the right child is the one taken
  } bhq_pick_t;

endpackage

/* hdl/bhq_ram.sv */
`timescale 1ns / 1ps

module bhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra_a,
  output logic [WIDTH-1:0]         rd_a,
  input  logic [$clog2(DEPTH)-1:0] ra_b,
  output logic [WIDTH-1:0]         rd_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

/* hdl/bhq_pick.sv */
`timescale 1ns / 1ps

module bhq_pick #(
  parameter int PW = 16
) (
  input  logic [PW-1:0]       cur_pri,
  input  logic [PW-1:0]       left_pri,
  input  logic [PW-1:0]       right_pri,
  input  logic                left_ok,
  input  logic                right_ok,
  output bhq_pkg::bhq_pick_t  pick
);

  import bhq_pkg::*;

  logic take_l;
  logic take_r;

  // left wins if smaller than the moving entry; right then has to beat
  // whichever is currently chosen
  assign take_l = left_ok && ($signed(left_pri) < $signed(cur_pri));
  assign take_r = right_ok && (take_l ? ($signed(right_pri) < $signed(left_pri))
                                      : ($signed(right_pri) < $signed(cur_pri)));

  assign pick.move  = take_l | take_r;
  assign pick.right = take_r;

endmodule

/* hdl/binary_min_heap_queue.sv */
`timescale 1ns / 1ps

// Binary min-heap priority queue of (priority, payload) entries held in one
// dual-read synchronous RAM. Each request is an enqueue or a dequeue and gives
// exactly one result: status (ok, dequeue on empty, enqueue on full), the
// dequeued priority and payload (zero otherwise) and the fill count after the
// request. Smaller priorities are served first; ties never move an entry.
// Requests are handled one at a time. An enqueue climbs the new entry from
// the end slot level by level; a dequeue fetches the root and the last entry
// together and sinks the last entry level by level. A refused request (full
// or empty) goes straight to the result. Each tree level costs one RAM read,
// compare and write-back. A new request is taken while the previous result
// still waits at the output register.
// Slots beyond the fill count may be read, but their contents are never
// used, so no clearing pass is needed after reset.

module binary_min_heap_queue #(
  parameter int HEAP_DEPTH     = 64,
  parameter int PRIORITY_WIDTH = 16,
  parameter int PAYLOAD_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic signed [PRIORITY_WIDTH-1:0]  in_priority,
  input  logic [PAYLOAD_WIDTH-1:0]          in_payload,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [PRIORITY_WIDTH-1:0]  out_priority,
  output logic [PAYLOAD_WIDTH-1:0]          out_payload,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]   out_fill_count
);

  import bhq_pkg::*;

  localparam int AW  = $clog2(HEAP_DEPTH);      // slot index
  localparam int CW  = $clog2(HEAP_DEPTH + 1);  // entry count
  localparam int CHW = AW + 2;                  // child index, unclipped
  localparam int EW  = PRIORITY_WIDTH + PAYLOAD_WIDTH;

  // state
  bhq_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] pos_r, pos_nxt;         // slot the moving entry occupies
  logic [EW-1:0] mov_r, mov_nxt;         // moving entry {priority, payload}

  // pending result
  logic [1:0]                res_status_r, res_status_nxt;
  logic [PRIORITY_WIDTH-1:0] res_pri_r, res_pri_nxt;
  logic [PAYLOAD_WIDTH-1:0]  res_pay_r, res_pay_nxt;
  logic [CW-1:0]             res_fill_r, res_fill_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [PRIORITY_WIDTH-1:0] out_pri_r, out_pri_nxt;
  logic [PAYLOAD_WIDTH-1:0]  out_pay_r, out_pay_nxt;
  logic [CW-1:0]             out_fill_r, out_fill_nxt;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [EW-1:0] ram_wd;
  logic [AW-1:0] ram_ra_a, ram_ra_b;
  logic [EW-1:0] ram_rd_a, ram_rd_b;

  // address arithmetic
  logic          accept;
  logic          out_free;
  logic [CW-1:0] last_idx;
  logic [AW-1:0] parent;
  logic [AW-1:0] grand;
  logic [CHW-1:0] child_l, child_r, count_ext;
  logic [AW-1:0]  pick_idx;
  logic [CHW-1:0] next_l, next_r;
  logic           up_swap;
  bhq_pick_t      pick;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign last_idx  = count_r - 1'b1;
  assign parent    = (pos_r - 1'b1) >> 1;
  assign grand     = (parent - 1'b1) >> 1;
  assign child_l   = {1'b0, pos_r, 1'b1};
  assign child_r   = child_l + 1'b1;
  assign count_ext = CHW'(count_r);
  assign pick_idx  = pick.right ? child_r[AW-1:0] : child_l[AW-1:0];
  assign next_l    = {1'b0, pick_idx, 1'b1};
  assign next_r    = next_l + 1'b1;

  // sift-up: move while strictly smaller than the parent
  assign up_swap = $signed(mov_r[EW-1 -: PRIORITY_WIDTH])
                 < $signed(ram_rd_a[EW-1 -: PRIORITY_WIDTH]);

  bhq_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_DEPTH)
  ) u_heap (
    .clk  (clk),
    .we   (ram_we),
    .wa   (ram_wa),
    .wd   (ram_wd),
    .ra_a (ram_ra_a),
    .rd_a (ram_rd_a),
    .ra_b (ram_ra_b),
    .rd_b (ram_rd_b)
  );

  // children beyond the fill count are stale slots and never win
  bhq_pick #(
    .PW (PRIORITY_WIDTH)
  ) u_pick (
    .cur_pri   (mov_r[EW-1 -: PRIORITY_WIDTH]),
    .left_pri  (ram_rd_a[EW-1 -: PRIORITY_WIDTH]),
    .right_pri (ram_rd_b[EW-1 -: PRIORITY_WIDTH]),
    .left_ok   (child_l < count_ext),
    .right_ok  (child_r < count_ext),
    .pick      (pick)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_ENQ) begin
            state_nxt = (count_r == CW'(HEAP_DEPTH)) ? ST_PUB : ST_UP_RD;
          end else begin
            state_nxt = (count_r == '0) ? ST_PUB : ST_DN_LD;
          end
        end
      end
      ST_UP_RD: begin
        state_nxt = (pos_r == '0) ? ST_PUB : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (!up_swap) begin
          state_nxt = ST_PUB;
        end else if (parent == '0) begin
          state_nxt = ST_UP_RD;   // root reached: final write next cycle
        end else begin
          state_nxt = ST_UP_CMP;
        end
      end
      ST_DN_LD: begin
        state_nxt = (count_r == '0) ? ST_PUB : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_nxt = pick.move ? ST_DN_CMP : ST_PUB;
      end
      ST_PUB: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    ram_we   = 1'b0;
    ram_wa   = pos_r;
    ram_wd   = mov_r;
    ram_ra_a = '0;
    ram_ra_b = '0;

    count_nxt      = count_r;
    pos_nxt        = pos_r;
    mov_nxt        = mov_r;
    res_status_nxt = res_status_r;
    res_pri_nxt    = res_pri_r;
    res_pay_nxt    = res_pay_r;
    res_fill_nxt   = res_fill_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pri_nxt    = out_pri_r;
    out_pay_nxt    = out_pay_r;
    out_fill_nxt   = out_fill_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_status_nxt = STAT_OK;
          res_pri_nxt    = '0;
          res_pay_nxt    = '0;
          res_fill_nxt   = count_r;
          if (in_operation == OP_ENQ) begin
            if (count_r == CW'(HEAP_DEPTH)) begin
              res_status_nxt = STAT_FULL;
            end else begin
              pos_nxt      = count_r[AW-1:0];
              count_nxt    = count_r + 1'b1;
              res_fill_nxt = count_r + 1'b1;
              mov_nxt      = {in_priority, in_payload};
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = STAT_EMPTY;
            end else begin
              // fetch root and last entry together
              count_nxt    = last_idx;
              res_fill_nxt = last_idx;
              pos_nxt      = '0;
              ram_ra_a     = '0;
              ram_ra_b     = last_idx[AW-1:0];
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_ra_a = parent;
        end
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (up_swap) begin
          // parent drops into the hole, keep climbing
          ram_wd   = ram_rd_a;
          pos_nxt  = parent;
          ram_ra_a = grand;
        end
      end
      ST_DN_LD: begin
        res_pri_nxt = ram_rd_a[EW-1 -: PRIORITY_WIDTH];
        res_pay_nxt = ram_rd_a[PAYLOAD_WIDTH-1:0];
        mov_nxt     = ram_rd_b;
        ram_ra_a    = child_l[AW-1:0];
        ram_ra_b    = child_r[AW-1:0];
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (pick.move) begin
          ram_wd   = pick.right ? ram_rd_b : ram_rd_a;
          pos_nxt  = pick_idx;
          ram_ra_a = next_l[AW-1:0];
          ram_ra_b = next_r[AW-1:0];
        end
      end
      ST_PUB: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pri_nxt    = res_pri_r;
          out_pay_nxt    = res_pay_r;
          out_fill_nxt   = res_fill_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    mov_r        <= mov_nxt;
    res_status_r <= res_status_nxt;
    res_pri_r    <= res_pri_nxt;
    res_pay_r    <= res_pay_nxt;
    res_fill_r   <= res_fill_nxt;
    out_status_r <= out_status_nxt;
    out_pri_r    <= out_pri_nxt;
    out_pay_r    <= out_pay_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_priority   = out_pri_r;
  assign out_payload    = out_pay_r;
  assign out_fill_count = out_fill_r;

endmodule

/* verif/binary_min_heap_queue_test.sv */
`timescale 1ns / 1ps

module binary_min_heap_queue_test;
  import bhq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int PRI_W       = 16;
  localparam int PAY_W       = 16;
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int MIX_ITEMS   = 110;
  // long result hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES = 300;
  // slack after the last result, well beyond the longest request
  localparam int DRAIN_SLACK = 40;
  localparam int CYCLE_LIMIT = 200000;

  // one result as the block reports it; priority kept as raw bits
  typedef struct packed {
    logic [1:0]        status;
    logic [PRI_W-1:0]  prio;
    logic [PAY_W-1:0]  pay;
    logic [FILL_W-1:0] fill;
  } heap_result_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct packed {
    logic         op;
    logic [PRI_W-1:0] prio;
    logic [PAY_W-1:0] pay;
    logic         typed;
    heap_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_stall;
  logic                     in_operation;
  logic signed [PRI_W-1:0]  in_priority;
  logic [PAY_W-1:0]         in_payload;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_status;
  logic signed [PRI_W-1:0]  out_priority;
  logic [PAY_W-1:0]         out_payload;
  logic [FILL_W-1:0]        out_fill_count;

  binary_min_heap_queue #(
    .HEAP_DEPTH     (DEPTH),
    .PRIORITY_WIDTH (PRI_W),
    .PAYLOAD_WIDTH  (PAY_W)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_priority    (in_priority),
    .in_payload     (in_payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_priority   (out_priority),
    .out_payload    (out_payload),
    .out_fill_count (out_fill_count)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow heap: our own copy of the tree, updated once per accepted
  // request, in the order requests are accepted.
  // ---------------------------------------------------------------------
  logic signed [PRI_W-1:0] heap_prio [DEPTH];
  logic [PAY_W-1:0]        heap_pay  [DEPTH];
  int                      heap_count;

  heap_result_t pending_results [$];

  // run statistics for the closing summary
  int error_count;
  int cycle_count;
  int requests_sent;
  int results_seen;
  int enq_ok;
  int deq_ok;
  int full_hits;
  int empty_hits;
  int peak_fill;

  // pacing knobs, in percent of cycles
  int send_idle_pct;
  int recv_stall_pct;

  // bumping hold_ticket asks the receiver for one long hold-off
  int hold_ticket;
  int hold_seen;
  int hold_left;

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic swap_slots(input int a, input int b);
    logic signed [PRI_W-1:0] tp;
    logic [PAY_W-1:0]        tv;
    tp = heap_prio[a];
    tv = heap_pay[a];
    heap_prio[a] = heap_prio[b];
    heap_pay[a]  = heap_pay[b];
    heap_prio[b] = tp;
    heap_pay[b]  = tv;
  endtask

  // Apply one request to the shadow heap and work out the result it owes.
  task automatic heap_apply(input logic op, input logic [PRI_W-1:0] prio,
                            input logic [PAY_W-1:0] pay, output heap_result_t res);
    int pos;
    int parent;
    int l;
    int r;
    int pick;
    bit done;
    res  = '0;
    done = 1'b0;
    if (op == OP_ENQ) begin
      if (heap_count >= DEPTH) begin
        // full: entry dropped, tree untouched
        res.status = STAT_FULL;
        full_hits++;
      end else begin
        pos = heap_count;
        heap_prio[pos] = prio;
        heap_pay[pos]  = pay;
        heap_count++;
        enq_ok++;
        // climb only while strictly smaller than the parent
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_prio[pos] >= heap_prio[parent]) begin
            done = 1'b1;
          end else begin
            swap_slots(pos, parent);
            pos = parent;
          end
        end
      end
    end else begin
      if (heap_count == 0) begin
        res.status = STAT_EMPTY;
        empty_hits++;
      end else begin
        res.prio = heap_prio[0];
        res.pay  = heap_pay[0];
        heap_count--;
        heap_prio[0] = heap_prio[heap_count];
        heap_pay[0]  = heap_pay[heap_count];
        deq_ok++;
        pos = 0;
        // sink: left if smaller than us, right if smaller than the left
        // (when left taken) or than us (when not); ties stay put
        while (!done) begin
          l = 2 * pos + 1;
          r = l + 1;
          pick = -1;
          if (l < heap_count && heap_prio[l] < heap_prio[pos])
            pick = l;
          if (r < heap_count &&
              ((pick < 0 && heap_prio[r] < heap_prio[pos]) ||
               (pick >= 0 && heap_prio[r] < heap_prio[l])))
            pick = r;
          if (pick < 0) begin
            done = 1'b1;
          end else begin
            swap_slots(pos, pick);
            pos = pick;
          end
        end
      end
    end
    res.fill = FILL_W'(heap_count);
    if (heap_count > peak_fill)
      peak_fill = heap_count;
  endtask

  // Priority mix: full range, a narrow band to force ties, a wider band around zero, and the extremes.
  function automatic logic [PRI_W-1:0] rand_priority();
    logic [PRI_W-1:0] p;
    case ($urandom_range(3))
      0: p = PRI_W'($urandom);
      1: p = PRI_W'($signed($urandom_range(8)) - 4);
      2: begin
        case ($urandom_range(3))
          0: p = {1'b1, {(PRI_W-1){1'b0}}};
          1: p = {1'b0, {(PRI_W-1){1'b1}}};
          2: p = '0;
          default: p = '1;
        endcase
      end
      default: p = PRI_W'($signed($urandom_range(200)) - 100);
    endcase
    return p;
  endfunction

  function automatic stim_row_t rand_request(input logic op);
    stim_row_t row;
    row      = '0;
    row.op   = op;
    row.prio = rand_priority();
    row.pay  = PAY_W'($urandom);
    return row;
  endfunction

  // Lean towards filling when nearly empty and draining when nearly full,
  // so the mixed traffic wanders over the whole range of fill.
  function automatic logic next_op();
    int enq_pct;
    if (heap_count < 8)
      enq_pct = 70;
    else if (heap_count > DEPTH - 8)
      enq_pct = 30;
    else
      enq_pct = 50;
    return ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
  endfunction

  function automatic stim_row_t stim_row(input logic op, input logic [PRI_W-1:0] prio,
                                         input logic [PAY_W-1:0] pay, input int typed,
                                         input logic [1:0] st, input logic [PRI_W-1:0] oprio,
                                         input logic [PAY_W-1:0] opay,
                                         input int fill);
    stim_row_t row;
    row.op          = op;
    row.prio        = prio;
    row.pay         = pay;
    row.typed       = (typed != 0);
    row.want.status = st;
    row.want.prio   = oprio;
    row.want.pay    = opay;
    row.want.fill   = FILL_W'(fill);
    return row;
  endfunction

  // Offer one request. Inputs move on the falling edge; acceptance is seen
  // at the rising edge. Valid is left high after acceptance so back-to-back
  // requests never drop it.
  task automatic send_request(input stim_row_t row);
    heap_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     = 1'b0;
      in_operation = 1'($urandom);
      in_priority  = PRI_W'($urandom);
      in_payload   = PAY_W'($urandom);
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = row.op;
    in_priority  = row.prio;
    in_payload   = row.pay;
    do @(posedge clk); while (in_stall);
    heap_apply(row.op, row.prio, row.pay, got);
    // typed rows are checked against the value written in the table
    pending_results.push_back(row.typed ? row.want : got);
    requests_sent++;
    @(negedge clk);
  endtask

  // Result side: random stalls, plus the occasional long hold-off counted
  // down here while the sender keeps pushing.
  always @(negedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Each accepted result is matched against the oldest outstanding one.
  always @(posedge clk) begin : check_results
    heap_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_priority !== want.prio)
          report_mismatch($sformatf("priority got %0d want %0d",
                                    out_priority, $signed(want.prio)));
        if (out_payload !== want.pay)
          report_mismatch($sformatf("payload got %h want %h", out_payload, want.pay));
        if (out_fill_count !== want.fill)
          report_mismatch($sformatf("fill got %0d want %0d", out_fill_count, want.fill));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t dir_rows [23];
    int ph;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_ENQ;
    in_priority    = '0;
    in_payload     = '0;
    heap_count     = 0;
    error_count    = 0;
    cycle_count    = 0;
    requests_sent  = 0;
    results_seen   = 0;
    enq_ok         = 0;
    deq_ok         = 0;
    full_hits      = 0;
    empty_hits     = 0;
    peak_fill      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ticket    = 0;
    hold_seen      = 0;
    hold_left      = 0;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Extremes and error codes carry their result inline;
    // the tie and ordering rows lean on the shadow heap.
    // dequeue straight after reset
    dir_rows[0]  = stim_row(OP_DEQ, 16'h0000, 16'h0000, 1, STAT_EMPTY, 16'h0000, 16'h0000, 0);
    // largest then smallest priority, both payload extremes
    dir_rows[1]  = stim_row(OP_ENQ, 16'h7fff, 16'hffff, 1, STAT_OK, 16'h0000, 16'h0000, 1);
    dir_rows[2]  = stim_row(OP_ENQ, 16'h8000, 16'h0000, 1, STAT_OK, 16'h0000, 16'h0000, 2);
    dir_rows[3]  = stim_row(OP_DEQ, 16'h0000, 16'h0000, 1, STAT_OK, 16'h8000, 16'h0000, 1);
    dir_rows[4]  = stim_row(OP_DEQ, 16'h0000, 16'h0000, 1, STAT_OK, 16'h7fff, 16'hffff, 0);
    // emptied again by dequeues
    dir_rows[5]  = stim_row(OP_DEQ, 16'hffff, 16'hffff, 1, STAT_EMPTY, 16'h0000, 16'h0000, 0);
    // equal priorities must keep their places; payloads tell them apart
    dir_rows[6]  = stim_row(OP_ENQ, 16'h0005, 16'h0001, 1, STAT_OK, 16'h0000, 16'h0000, 1);
    dir_rows[7]  = stim_row(OP_ENQ, 16'h0005, 16'h0002, 0, STAT_OK, '0, '0, 0);
    dir_rows[8]  = stim_row(OP_ENQ, 16'h0005, 16'h0003, 0, STAT_OK, '0, '0, 0);
    dir_rows[9]  = stim_row(OP_ENQ, 16'h0003, 16'h0004, 0, STAT_OK, '0, '0, 0);
    dir_rows[10] = stim_row(OP_ENQ, 16'hffff, 16'h0005, 0, STAT_OK, '0, '0, 0);
    dir_rows[11] = stim_row(OP_ENQ, 16'h0005, 16'h0006, 0, STAT_OK, '0, '0, 0);
    dir_rows[12] = stim_row(OP_ENQ, 16'h0004, 16'h5555, 0, STAT_OK, '0, '0, 0);
    dir_rows[13] = stim_row(OP_ENQ, 16'h0003, 16'haaaa, 0, STAT_OK, '0, '0, 0);
    for (int i = 14; i < 22; i++)
      dir_rows[i] = stim_row(OP_DEQ, 16'h0000, 16'h0000, 0, STAT_OK, '0, '0, 0);
    dir_rows[22] = stim_row(OP_DEQ, 16'h0000, 16'h0000, 1, STAT_EMPTY, 16'h0000, 16'h0000, 0);

    foreach (dir_rows[i])
      send_request(dir_rows[i]);

    // Random part, four pacing phases.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase

      // hold the result side off and keep the requests coming
      if (ph == 1) begin
        hold_ticket++;
        repeat (20) send_request(rand_request(OP_ENQ));
      end

      // full sweep: fill to the brim, knock on the full heap, drain, and
      // knock on the empty one
      if (ph == 0 || ph == 3) begin
        while (heap_count < DEPTH)
          send_request(rand_request(OP_ENQ));
        repeat (2) send_request(rand_request(OP_ENQ));
        while (heap_count > 0)
          send_request(rand_request(OP_DEQ));
        send_request(rand_request(OP_DEQ));
      end

      repeat (MIX_ITEMS) send_request(rand_request(next_op()));
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("Run: %0d requests, %0d results checked; %0d enqueues, %0d dequeues served",
             requests_sent, results_seen, enq_ok, deq_ok);
    $display("Run: %0d refused on full, %0d on empty, peak fill %0d, errors %0d",
             full_hits, empty_hits, peak_fill, error_count);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
